/* rtl/assert_macros.svh */
// Assertion macros shared by the grid scale partition table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define GSP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define GSP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gsp_pkg.sv */
// Package for the grid scale partition table: field widths, operation and
// status codes, reset values. No dependencies.
`timescale 1ns / 1ps

package gsp_pkg;

   localparam int DEFAULT_MAX_GRID_SIZE = 64;

   localparam int OP_W     = 2;
   localparam int COORD_W  = 64;
   localparam int QIDX_W   = 6;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 15;
   localparam int GRID_W   = 7;

   localparam logic [GRID_W-1:0] GRID_SIZE_RESET = 7'd64;

   // directory layout: base word, then five words per cell
   localparam int DIR_BASE        = 1;
   localparam int DIR_ENTRY_WORDS = 5;

   localparam logic [OP_W-1:0] OP_LOCATE = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_GET    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

/* rtl/gsp_req_if.sv */
// Request channel of the grid scale partition table: valid/ready plus the
// item payload. Depends on gsp_pkg.
`timescale 1ns / 1ps

interface gsp_req_if import gsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   coord_type           coord_x;
   coord_type           coord_y;
   logic                axis_is_x;
   coord_type           partition_value;
   logic [QIDX_W-1:0]   query_lon;
   logic [QIDX_W-1:0]   query_lat;

   modport source (
      output valid, operation, coord_x, coord_y, axis_is_x, partition_value,
             query_lon, query_lat,
      input  ready
   );

   modport sink (
      input  valid, operation, coord_x, coord_y, axis_is_x, partition_value,
             query_lon, query_lat,
      output ready
   );
endinterface

/* rtl/gsp_rsp_if.sv */
// Response channel of the grid scale partition table: valid/ready plus the
// result payload. Depends on gsp_pkg.
`timescale 1ns / 1ps

interface gsp_rsp_if import gsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [QIDX_W-1:0]   found_lon;
   logic [QIDX_W-1:0]   found_lat;
   logic [OFFSET_W-1:0] directory_offset;
   coord_type           bound_x;
   coord_type           bound_y;

   modport source (
      output valid, status, found_lon, found_lat, directory_offset, bound_x, bound_y,
      input  ready
   );

   modport sink (
      input  valid, status, found_lon, found_lat, directory_offset, bound_x, bound_y,
      output ready
   );
endinterface

/* rtl/gsp_scale_ram.sv */
// One linear scale: synchronous memory, one write and one read port,
// registered read data. Depends on gsp_pkg.
`timescale 1ns / 1ps

module gsp_scale_ram import gsp_pkg::*; #(
   parameter int DEPTH  = DEFAULT_MAX_GRID_SIZE - 1,
   parameter int ADDR_W = 6,
   parameter int DATA_W = COORD_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gsp_dir_offset.sv */
// Directory word offset of a cell: base + words_per_entry * (lon*size + lat),
// kept to the offset field width. Depends on gsp_pkg.
`timescale 1ns / 1ps

module gsp_dir_offset import gsp_pkg::*; #(
   parameter int MAX_GRID_SIZE = DEFAULT_MAX_GRID_SIZE
) (
   input  logic [$clog2(MAX_GRID_SIZE)-1:0]   lon,
   input  logic [$clog2(MAX_GRID_SIZE)-1:0]   lat,
   input  logic [$clog2(MAX_GRID_SIZE+1)-1:0] eff_size,
   output logic [OFFSET_W-1:0]                offset
);

   localparam int CNT_W  = $clog2(MAX_GRID_SIZE);
   localparam int SZ_W   = $clog2(MAX_GRID_SIZE + 1);
   localparam int PROD_W = CNT_W + SZ_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int FULL_W = SUM_W + 3;
   localparam int CALC_W = (FULL_W > OFFSET_W) ? FULL_W : OFFSET_W;

   logic [PROD_W-1:0] product;
   logic [SUM_W-1:0]  cell_index;
   logic [CALC_W-1:0] offset_full;

   assign product     = lon * eff_size;
   assign cell_index  = {1'b0, product} + SUM_W'(lat);
   assign offset_full = CALC_W'(cell_index) * CALC_W'(DIR_ENTRY_WORDS) + CALC_W'(DIR_BASE);
   assign offset      = offset_full[OFFSET_W-1:0];

endmodule

/* rtl/grid_scale_partition_table.sv */
// Top level of the grid scale partition table: request/response channels,
// grid size register, sequencer. Depends on gsp_pkg, gsp_req_if, gsp_rsp_if,
// gsp_scale_ram, gsp_dir_offset and assert_macros.svh.
//
// The block holds the two linear scales of a 2-D grid file, each an ascending
// list of signed 64-bit partitions in its own single-port-read memory. A
// locate item returns, per axis, how many leading partitions lie strictly
// below the coordinate, plus the cell's directory offset
// 1 + 5*(lon*grid_size + lat); an insert item places a value in sorted order
// (equal values go in front) or reports full once grid_size-1 values are
// held; a get item returns the partitions at lon-1 and lat-1 (clamped at
// zero) or out of range. Items are worked one at a time. A locate scans both
// scales side by side, one entry per cycle, and ends each scan on a
// partition at or above the coordinate or once it runs past every held
// entry; an insert shifts the entries above its slot up one per cycle. The
// single read port of each scale memory paces both. A finished result sits
// in an output register, so the next item is taken while it waits.
// grid_size is to be written through csr_wr_en/csr_wr_data only while no
// item is in flight; the block itself does not enforce this. Values outside
// 2..MAX_GRID_SIZE act saturated. No clearing pass follows reset: entries at
// or above a scale's count are never read as data.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_scale_partition_table import gsp_pkg::*; #(
   parameter int MAX_GRID_SIZE = DEFAULT_MAX_GRID_SIZE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [GRID_W-1:0] csr_wr_data,
   gsp_req_if.sink           req_chan,
   gsp_rsp_if.source         rsp_chan
);

   localparam int SCALE_DEPTH = MAX_GRID_SIZE - 1;
   localparam int CNT_W       = $clog2(MAX_GRID_SIZE);
   localparam int SZ_W        = $clog2(MAX_GRID_SIZE + 1);
   localparam int ADDR_W      = ($clog2(SCALE_DEPTH) < 1) ? 1 : $clog2(SCALE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOC  = 5'b00010,
      S_INS  = 5'b00100,
      S_PUT  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [GRID_W-1:0]   grid_size_ff;
   logic [CNT_W-1:0]    x_count_ff, x_count_in;
   logic [CNT_W-1:0]    y_count_ff, y_count_in;
   logic                x_busy_ff, x_busy_in;
   logic                y_busy_ff, y_busy_in;
   logic                rsp_valid_ff;

   // item context
   logic [OP_W-1:0]     op_ff, op_in;
   logic                axis_ff, axis_in;
   coord_type           val_ff, val_in;
   coord_type           yv_ff, yv_in;
   logic [CNT_W-1:0]    x_ptr_ff, x_ptr_in;
   logic [CNT_W-1:0]    y_ptr_ff, y_ptr_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // response payload
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [QIDX_W-1:0]   rsp_lon_ff;
   logic [QIDX_W-1:0]   rsp_lat_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   coord_type           rsp_bound_x_ff;
   coord_type           rsp_bound_y_ff;

   // memory ports
   logic                x_rd_en, y_rd_en, x_wr_en, y_wr_en;
   logic [ADDR_W-1:0]   x_rd_addr, y_rd_addr, x_wr_addr, y_wr_addr;
   coord_type           x_wr_data, y_wr_data;
   coord_type           x_rd_data, y_rd_data;

   logic [SZ_W-1:0]     eff_size;
   logic [OFFSET_W-1:0] dir_offset;
   logic                req_fire;
   logic [CNT_W-1:0]    req_count;
   logic                req_full;
   logic                get_bad;
   logic [CNT_W-1:0]    x_ptr_next, y_ptr_next;
   logic                x_loc_gt, y_loc_gt, ins_gt;
   logic                load_rsp;
   logic                cell_ok;
   logic                get_ok;

   gsp_scale_ram #(
      .DEPTH  (SCALE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (COORD_W)
   ) u_x_scale (
      .clock   (clock),
      .wr_en   (x_wr_en),
      .wr_addr (x_wr_addr),
      .wr_data (x_wr_data),
      .rd_en   (x_rd_en),
      .rd_addr (x_rd_addr),
      .rd_data (x_rd_data)
   );

   gsp_scale_ram #(
      .DEPTH  (SCALE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (COORD_W)
   ) u_y_scale (
      .clock   (clock),
      .wr_en   (y_wr_en),
      .wr_addr (y_wr_addr),
      .wr_data (y_wr_data),
      .rd_en   (y_rd_en),
      .rd_addr (y_rd_addr),
      .rd_data (y_rd_data)
   );

   gsp_dir_offset #(
      .MAX_GRID_SIZE (MAX_GRID_SIZE)
   ) u_dir_offset (
      .lon      (x_ptr_ff),
      .lat      (y_ptr_ff),
      .eff_size (eff_size),
      .offset   (dir_offset)
   );

   // saturate the grid size register to 2..MAX_GRID_SIZE
   always_comb begin
      if (int'(grid_size_ff) < 2) begin
         eff_size = SZ_W'(2);
      end else if (int'(grid_size_ff) > MAX_GRID_SIZE) begin
         eff_size = SZ_W'(MAX_GRID_SIZE);
      end else begin
         eff_size = SZ_W'(grid_size_ff);
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_count      = req_chan.axis_is_x ? x_count_ff : y_count_ff;
   assign req_full       = (SZ_W'(req_count) + SZ_W'(1)) >= eff_size;
   assign get_bad        = (int'(req_chan.query_lon) > int'(x_count_ff)) ||
                           (int'(req_chan.query_lat) > int'(y_count_ff));

   assign x_ptr_next = CNT_W'(x_ptr_ff + 1'b1);
   assign y_ptr_next = CNT_W'(y_ptr_ff + 1'b1);
   assign x_loc_gt   = val_ff > x_rd_data;
   assign y_loc_gt   = yv_ff > y_rd_data;
   assign ins_gt     = axis_ff ? (val_ff > x_rd_data) : (val_ff > y_rd_data);

   // sequencer: each scale memory is read one entry per cycle; writes during
   // an insert land one slot above the entry being read, so no access overlaps
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      axis_in    = axis_ff;
      val_in     = val_ff;
      yv_in      = yv_ff;
      x_ptr_in   = x_ptr_ff;
      y_ptr_in   = y_ptr_ff;
      x_busy_in  = x_busy_ff;
      y_busy_in  = y_busy_ff;
      status_in  = status_ff;
      x_count_in = x_count_ff;
      y_count_in = y_count_ff;
      x_rd_en    = 1'b0;
      y_rd_en    = 1'b0;
      x_rd_addr  = '0;
      y_rd_addr  = '0;
      x_wr_en    = 1'b0;
      y_wr_en    = 1'b0;
      x_wr_addr  = '0;
      y_wr_addr  = '0;
      x_wr_data  = val_ff;
      y_wr_data  = val_ff;
      load_rsp   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_chan.operation;
               axis_in   = req_chan.axis_is_x;
               val_in    = req_chan.coord_x;
               yv_in     = req_chan.coord_y;
               status_in = STATUS_OK;
               x_ptr_in  = '0;
               y_ptr_in  = '0;
               x_busy_in = 1'b0;
               y_busy_in = 1'b0;
               state_in  = S_DONE;
               unique case (req_chan.operation)
                  OP_LOCATE: begin
                     // start both scans at entry zero unless the scale is empty
                     x_busy_in = (x_count_ff != '0);
                     y_busy_in = (y_count_ff != '0);
                     x_rd_en   = (x_count_ff != '0);
                     y_rd_en   = (y_count_ff != '0);
                     state_in  = S_LOC;
                  end
                  OP_INSERT: begin
                     val_in = req_chan.partition_value;
                     if (req_full) begin
                        status_in = STATUS_FULL;
                     end else if (req_count == '0) begin
                        state_in = S_PUT;
                     end else begin
                        // walk down from the top held entry
                        state_in = S_INS;
                        if (req_chan.axis_is_x) begin
                           x_ptr_in  = CNT_W'(req_count - 1'b1);
                           x_rd_en   = 1'b1;
                           x_rd_addr = ADDR_W'(req_count - 1'b1);
                        end else begin
                           y_ptr_in  = CNT_W'(req_count - 1'b1);
                           y_rd_en   = 1'b1;
                           y_rd_addr = ADDR_W'(req_count - 1'b1);
                        end
                     end
                  end
                  OP_GET: begin
                     if (get_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        // fetch the lower bounds; data is ready in the done state
                        x_ptr_in  = CNT_W'(req_chan.query_lon);
                        y_ptr_in  = CNT_W'(req_chan.query_lat);
                        x_rd_en   = 1'b1;
                        y_rd_en   = 1'b1;
                        x_rd_addr = (req_chan.query_lon == '0) ? '0 :
                                    ADDR_W'(req_chan.query_lon - 1'b1);
                        y_rd_addr = (req_chan.query_lat == '0) ? '0 :
                                    ADDR_W'(req_chan.query_lat - 1'b1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_LOC: begin
            if (x_busy_ff) begin
               if (x_loc_gt) begin
                  x_ptr_in = x_ptr_next;
                  if (x_ptr_next == x_count_ff) begin
                     x_busy_in = 1'b0;
                  end else begin
                     x_rd_en   = 1'b1;
                     x_rd_addr = ADDR_W'(x_ptr_next);
                  end
               end else begin
                  x_busy_in = 1'b0;
               end
            end
            if (y_busy_ff) begin
               if (y_loc_gt) begin
                  y_ptr_in = y_ptr_next;
                  if (y_ptr_next == y_count_ff) begin
                     y_busy_in = 1'b0;
                  end else begin
                     y_rd_en   = 1'b1;
                     y_rd_addr = ADDR_W'(y_ptr_next);
                  end
               end else begin
                  y_busy_in = 1'b0;
               end
            end
            if (!x_busy_ff && !y_busy_ff) begin
               state_in = S_DONE;
            end
         end

         S_INS: begin
            // move the entry up one slot, or drop the value in above it
            if (axis_ff) begin
               x_wr_en   = 1'b1;
               x_wr_addr = ADDR_W'(x_ptr_next);
               x_wr_data = ins_gt ? val_ff : x_rd_data;
               if (ins_gt) begin
                  x_count_in = CNT_W'(x_count_ff + 1'b1);
                  state_in   = S_DONE;
               end else if (x_ptr_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  x_ptr_in  = CNT_W'(x_ptr_ff - 1'b1);
                  x_rd_en   = 1'b1;
                  x_rd_addr = ADDR_W'(x_ptr_ff - 1'b1);
               end
            end else begin
               y_wr_en   = 1'b1;
               y_wr_addr = ADDR_W'(y_ptr_next);
               y_wr_data = ins_gt ? val_ff : y_rd_data;
               if (ins_gt) begin
                  y_count_in = CNT_W'(y_count_ff + 1'b1);
                  state_in   = S_DONE;
               end else if (y_ptr_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  y_ptr_in  = CNT_W'(y_ptr_ff - 1'b1);
                  y_rd_en   = 1'b1;
                  y_rd_addr = ADDR_W'(y_ptr_ff - 1'b1);
               end
            end
         end

         S_PUT: begin
            // value goes at the bottom slot held in the pointer
            if (axis_ff) begin
               x_wr_en    = 1'b1;
               x_wr_addr  = ADDR_W'(x_ptr_ff);
               x_count_in = CNT_W'(x_count_ff + 1'b1);
            end else begin
               y_wr_en    = 1'b1;
               y_wr_addr  = ADDR_W'(y_ptr_ff);
               y_count_in = CNT_W'(y_count_ff + 1'b1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cell_ok = (status_ff == STATUS_OK) && ((op_ff == OP_LOCATE) || (op_ff == OP_GET));
   assign get_ok  = (status_ff == STATUS_OK) && (op_ff == OP_GET);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grid_size_ff <= GRID_SIZE_RESET;
         x_count_ff   <= '0;
         y_count_ff   <= '0;
         x_busy_ff    <= 1'b0;
         y_busy_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         x_count_ff <= x_count_in;
         y_count_ff <= y_count_in;
         x_busy_ff  <= x_busy_in;
         y_busy_ff  <= y_busy_in;
         if (csr_wr_en) begin
            grid_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      axis_ff   <= axis_in;
      val_ff    <= val_in;
      yv_ff     <= yv_in;
      x_ptr_ff  <= x_ptr_in;
      y_ptr_ff  <= y_ptr_in;
      status_ff <= status_in;
   end

   // output register: a new result loads while the old one drains
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff  <= status_ff;
         rsp_lon_ff     <= cell_ok ? QIDX_W'(x_ptr_ff) : '0;
         rsp_lat_ff     <= cell_ok ? QIDX_W'(y_ptr_ff) : '0;
         rsp_offset_ff  <= cell_ok ? dir_offset : '0;
         // an empty scale holds no written entry: its bound reads as zero
         rsp_bound_x_ff <= (get_ok && (x_count_ff != '0)) ? x_rd_data : '0;
         rsp_bound_y_ff <= (get_ok && (y_count_ff != '0)) ? y_rd_data : '0;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.found_lon        = rsp_lon_ff;
   assign rsp_chan.found_lat        = rsp_lat_ff;
   assign rsp_chan.directory_offset = rsp_offset_ff;
   assign rsp_chan.bound_x          = rsp_bound_x_ff;
   assign rsp_chan.bound_y          = rsp_bound_y_ff;

   `GSP_ASSERT_ALWAYS(a_count_in_depth, clock, reset, (int'(x_count_ff) <= SCALE_DEPTH) && (int'(y_count_ff) <= SCALE_DEPTH), "scale count beyond memory depth")
   `GSP_ASSERT_IMPLIES(a_loc_x_in_range, clock, reset, (state_ff == S_LOC) && x_busy_ff, x_ptr_ff < x_count_ff, "x scan past held entries")
   `GSP_ASSERT_IMPLIES(a_loc_y_in_range, clock, reset, (state_ff == S_LOC) && y_busy_ff, y_ptr_ff < y_count_ff, "y scan past held entries")
   `GSP_ASSERT_IMPLIES(a_ins_in_range, clock, reset, (state_ff == S_INS), axis_ff ? (x_ptr_ff < x_count_ff) : (y_ptr_ff < y_count_ff), "insert shift past held entries")
   `GSP_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE, "accepted item did not start")

endmodule
